[sv/mck_pkg.sv]
// Shared types, constants and the character code tables of the Morse keyer.
package mck_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned TimeW = 12;
  localparam int unsigned DurW  = 13;
  localparam int unsigned CodeW = 7;
  localparam int unsigned ElemW = 6;
  localparam int unsigned CntW  = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgIdxDot  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxDash = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxGap  = 2'd2;

  localparam logic [TimeW-1:0] DotReset  = 12'd100;
  localparam logic [TimeW-1:0] DashReset = 12'd300;
  localparam logic [TimeW-1:0] GapReset  = 12'd50;

  localparam logic [CharW-1:0] CharSpace = 8'h20;

  // Code: leading 1 marker, then elements MSB first; 1 = dash, 0 = dot.
  localparam logic [CodeW-1:0] LatinCodes [26] = '{
    7'd5, 7'd24, 7'd26, 7'd12, 7'd2, 7'd18, 7'd14, 7'd16, 7'd4, 7'd23, 7'd13, 7'd20, 7'd7,
    7'd6, 7'd15, 7'd22, 7'd29, 7'd10, 7'd8, 7'd3, 7'd9, 7'd17, 7'd11, 7'd25, 7'd27, 7'd28
  };

  localparam logic [CodeW-1:0] DigitCodes [10] = '{
    7'd63, 7'd47, 7'd39, 7'd35, 7'd33, 7'd32, 7'd48, 7'd56, 7'd60, 7'd62
  };

  localparam logic [CodeW-1:0] CyrCodes [32] = '{
    7'd5, 7'd24, 7'd11, 7'd14, 7'd12, 7'd2, 7'd17, 7'd28,
    7'd4, 7'd23, 7'd13, 7'd20, 7'd7, 7'd6, 7'd15, 7'd22,
    7'd10, 7'd8, 7'd3, 7'd9, 7'd18, 7'd16, 7'd26, 7'd30,
    7'd31, 7'd29, 7'd90, 7'd27, 7'd25, 7'd36, 7'd19, 7'd21
  };

  localparam logic [CodeW-1:0] CodePeriod   = 7'd85;
  localparam logic [CodeW-1:0] CodeComma    = 7'd115;
  localparam logic [CodeW-1:0] CodeQuestion = 7'd76;
  localparam logic [CodeW-1:0] CodeNone     = 7'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TONE,
    S_GAP,
    S_CLOSE,
    S_STOP
  } seq_state_e;

  typedef struct packed {
    logic [TimeW-1:0] dot;
    logic [TimeW-1:0] dash;
    logic [TimeW-1:0] gap;
  } cfg_t;

  // Windows-1251 byte to Morse code, 0 when the byte has no code.
  function automatic logic [CodeW-1:0] code_of(input logic [CharW-1:0] ch);
    logic [CharW-1:0] c;
    logic [CodeW-1:0] code;
    logic [4:0]       lat_idx;
    c = ch;
    if (c inside {[8'h41:8'h5A]}) c = c + 8'h20;
    if (c inside {[8'hC0:8'hDF]}) c = c + 8'h20;
    if (c == 8'hA8 || c == 8'hB8) c = 8'hE5;
    lat_idx = c[4:0] - 5'd1;
    if (c inside {[8'h61:8'h7A]}) code = LatinCodes[lat_idx];
    else if (c inside {[8'h30:8'h39]}) code = DigitCodes[c[3:0]];
    else if (c >= 8'hE0) code = CyrCodes[c[4:0]];
    else if (c == 8'h2E) code = CodePeriod;
    else if (c == 8'h2C) code = CodeComma;
    else if (c == 8'h3F) code = CodeQuestion;
    else code = CodeNone;
    return code;
  endfunction

endpackage

[sv/mck_if.sv]
// Valid/ready stream interfaces for character words and segment words.
interface mck_char_if;
  logic                        valid;
  logic                        ready;
  logic [mck_pkg::CharW-1:0]   char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface mck_seg_if;
  logic                       valid;
  logic                       ready;
  logic                       tone_on;
  logic [mck_pkg::DurW-1:0]   duration_ms;
  logic                       stop;
  logic                       last;

  modport source (output valid, output tone_on, output duration_ms, output stop,
                  output last, input ready);
  modport sink   (input valid, input tone_on, input duration_ms, input stop,
                  input last, output ready);
endinterface

[sv/mck_cfg_regs.sv]
// Timing register file: dot, dash and gap lengths.
module mck_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mck_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mck_pkg::TimeW-1:0]     cfg_wdata_i,
  output mck_pkg::cfg_t                 cfg_o
);

  mck_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mck_pkg::CfgIdxDot:  cfg_d.dot  = cfg_wdata_i;
        mck_pkg::CfgIdxDash: cfg_d.dash = cfg_wdata_i;
        mck_pkg::CfgIdxGap:  cfg_d.gap  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot  <= mck_pkg::DotReset;
      cfg_q.dash <= mck_pkg::DashReset;
      cfg_q.gap  <= mck_pkg::GapReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/mck_seq.sv]
// Element sequencer: code shift register, element counter and output register.
module mck_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mck_pkg::cfg_t     cfg_i,
  mck_char_if.sink          char_i,
  mck_seg_if.source         seg_o
);

  mck_pkg::seq_state_e state_q, state_d;

  logic [mck_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [mck_pkg::ElemW-1:0] elem_q, elem_d;

  logic                      out_vq, out_vd;
  logic                      tone_q, tone_d;
  logic [mck_pkg::DurW-1:0]  dur_q, dur_d;
  logic                      stop_q, stop_d;
  logic                      last_q, last_d;

  logic [mck_pkg::CodeW-1:0]  code_w;
  logic [mck_pkg::CntW-1:0]   len_w;
  logic [mck_pkg::ElemW-1:0]  align_w;
  logic                       out_free;
  logic [mck_pkg::DurW-1:0]   gap_w;
  logic [mck_pkg::DurW-1:0]   gap2_w;

  assign code_w   = mck_pkg::code_of(char_i.char_code);
  assign out_free = !out_vq || seg_o.ready;
  assign gap_w    = {1'b0, cfg_i.gap};
  assign gap2_w   = {cfg_i.gap, 1'b0};

  // Marker position gives the element count.
  always_comb begin
    if (code_w[6])      len_w = 3'd6;
    else if (code_w[5]) len_w = 3'd5;
    else if (code_w[4]) len_w = 3'd4;
    else if (code_w[3]) len_w = 3'd3;
    else if (code_w[2]) len_w = 3'd2;
    else                len_w = 3'd1;
  end

  // First element goes to the top bit.
  assign align_w = code_w[mck_pkg::ElemW-1:0] << (3'd6 - len_w);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    elem_d  = elem_q;
    out_vd  = out_vq && !seg_o.ready;
    tone_d  = tone_q;
    dur_d   = dur_q;
    stop_d  = stop_q;
    last_d  = last_q;
    case (state_q)
      mck_pkg::S_IDLE: begin
        if (char_i.valid) begin
          if (char_i.char_code == mck_pkg::CharSpace) begin
            cnt_d   = '0;
            state_d = mck_pkg::S_GAP;
          end else if (code_w == mck_pkg::CodeNone) begin
            state_d = mck_pkg::S_STOP;
          end else begin
            cnt_d   = len_w;
            elem_d  = align_w;
            state_d = mck_pkg::S_TONE;
          end
        end
      end
      mck_pkg::S_TONE: begin
        if (out_free) begin
          out_vd  = 1'b1;
          tone_d  = 1'b1;
          dur_d   = {1'b0, (elem_q[mck_pkg::ElemW-1] ? cfg_i.dash : cfg_i.dot)};
          stop_d  = 1'b0;
          last_d  = 1'b0;
          elem_d  = elem_q << 1;
          cnt_d   = cnt_q - 3'd1;
          state_d = mck_pkg::S_GAP;
        end
      end
      mck_pkg::S_GAP: begin
        if (out_free) begin
          out_vd  = 1'b1;
          tone_d  = 1'b0;
          dur_d   = gap_w;
          stop_d  = 1'b0;
          last_d  = 1'b0;
          state_d = (cnt_q == '0) ? mck_pkg::S_CLOSE : mck_pkg::S_TONE;
        end
      end
      mck_pkg::S_CLOSE: begin
        if (out_free) begin
          out_vd  = 1'b1;
          tone_d  = 1'b0;
          dur_d   = gap2_w;
          stop_d  = 1'b0;
          last_d  = 1'b1;
          state_d = mck_pkg::S_IDLE;
        end
      end
      mck_pkg::S_STOP: begin
        if (out_free) begin
          out_vd  = 1'b1;
          tone_d  = 1'b0;
          dur_d   = '0;
          stop_d  = 1'b1;
          last_d  = 1'b1;
          state_d = mck_pkg::S_IDLE;
        end
      end
      default: state_d = mck_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mck_pkg::S_IDLE;
      cnt_q   <= '0;
      out_vq  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      out_vq  <= out_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    tone_q <= tone_d;
    dur_q  <= dur_d;
    stop_q <= stop_d;
    last_q <= last_d;
  end

  assign char_i.ready      = (state_q == mck_pkg::S_IDLE);
  assign seg_o.valid       = out_vq;
  assign seg_o.tone_on     = tone_q;
  assign seg_o.duration_ms = dur_q;
  assign seg_o.stop        = stop_q;
  assign seg_o.last        = last_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_i.valid && char_i.ready |=> state_q != mck_pkg::S_IDLE)
    else $error("word accepted but sequencer stayed idle");

  a_tone_has_element: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mck_pkg::S_TONE |-> cnt_q != '0)
    else $error("tone state with no element left");

  a_stop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq && stop_q |-> last_q && !tone_q && dur_q == '0)
    else $error("malformed stop word");

  a_tone_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq && tone_q |-> !last_q && !stop_q)
    else $error("tone segment flagged as last");

endmodule

[sv/morse_code_keyer.sv]
// Morse keyer top level: timing registers and element sequencer.
// The first segment word of a character is formed in the state after S_IDLE.
// A character of n elements gives 2n+1 segment words (tones, gaps and a closing
// gap); a space gives two and a byte with no code one stop word. One segment per
// cycle while seg_o is ready; new characters are taken only in S_IDLE.
// Reset: asynchronous active low; timing registers return to 100/300/50 ms.
module morse_code_keyer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mck_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mck_pkg::TimeW-1:0]     cfg_wdata_i,
  mck_char_if.sink                      char_i,
  mck_seg_if.source                     seg_o
);

  mck_pkg::cfg_t cfg;

  mck_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mck_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .char_i (char_i),
    .seg_o  (seg_o)
  );

endmodule
